@@ hw/rtl/slm_pkg.sv @@
// Shared types and state encoding for the sorted list merge set-operation block.
// No dependencies; used by slm_merge and sorted_list_merge_set_op.
package slm_pkg;

  // Input transaction payload: one list element or a list close mark
  typedef struct packed {
    logic               which_list;
    logic signed [31:0] element;
    logic               list_closed;
    logic               list_empty;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [31:0] out_value;
    logic               no_result;
    logic               overflowed;
    logic               run_last;
  } out_t;

  // Set operation selected by the mode register
  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_INTER = 1'b1;

  // Merge sequencer states
  typedef enum logic [1:0] {
    MS_IDLE,
    MS_FETCH,
    MS_CMP,
    MS_FINISH
  } merge_state_t;

  // Load side to merge sequencer
  typedef struct packed {
    logic start;
    logic inter;
    logic drop;
  } slm_ctrl_t;

  // Merge sequencer back to load side
  typedef struct packed {
    logic busy;
    logic done;
  } slm_stat_t;

endpackage

@@ hw/rtl/slm_store.sv @@
// Element storage for lists A and B: one write port shared by both lists,
// one registered read port per list. No dependencies.
module slm_store #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic                                   wr_sel,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic signed [31:0]                     wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic signed [31:0]                     rd_data_a,
  output logic signed [31:0]                     rd_data_b
);

  logic signed [31:0] mem_a [DEPTH];
  logic signed [31:0] mem_b [DEPTH];

  // Write the element into the list it names
  always_ff @(posedge clk) begin
    if (wr_en && !wr_sel) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (wr_en && wr_sel) begin
      mem_b[wr_addr] <= wr_data;
    end
  end

  // Registered read of both list heads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem_a[rd_addr_a];
      rd_data_b <= mem_b[rd_addr_b];
    end
  end

endmodule

@@ hw/rtl/slm_merge.sv @@
// Two-pointer merge sequencer with a single signed comparator, a one-deep
// hold stage for run_last look-ahead and the result register. Uses slm_pkg.
module slm_merge #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  slm_pkg::slm_ctrl_t                     ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]             cnt_a,
  input  logic [$clog2(DEPTH+1)-1:0]             cnt_b,
  output slm_pkg::slm_stat_t                     stat,
  output logic                                   rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  input  logic signed [31:0]                     rd_data_a,
  input  logic signed [31:0]                     rd_data_b,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output slm_pkg::out_t                          out_data
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slm_pkg::merge_state_t state_r, state_nxt;
  logic [CW-1:0]         ia_r, ib_r;
  logic                  inter_r;
  slm_pkg::out_t         hold_r;
  logic                  hold_vld_r;
  slm_pkg::out_t         out_r;
  logic                  out_vld_r;

  logic                  a_has, b_has, run_end, out_free;
  logic                  lt, eq;
  logic                  take_a, take_b, emit, blocked;
  logic signed [31:0]    pick;
  logic                  adv_a, adv_b, load_hold, push, finish;

  // Pointer status and the shared comparator
  assign a_has    = ia_r < cnt_a;
  assign b_has    = ib_r < cnt_b;
  assign run_end  = (!a_has && !b_has) || (inter_r && (!a_has || !b_has));
  assign out_free = !out_vld_r || !out_stall;
  assign lt       = rd_data_a < rd_data_b;
  assign eq       = rd_data_a == rd_data_b;

  // Decide which heads advance and what is emitted
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    emit   = 1'b0;
    pick   = rd_data_a;
    if (a_has && b_has) begin
      if (lt) begin
        take_a = 1'b1;
        emit   = !inter_r;
      end else if (eq) begin
        take_a = 1'b1;
        take_b = 1'b1;
        emit   = 1'b1;
      end else begin
        take_b = 1'b1;
        emit   = !inter_r;
        pick   = rd_data_b;
      end
    end else if (a_has) begin
      take_a = 1'b1;
      emit   = 1'b1;
    end else begin
      take_b = 1'b1;
      emit   = 1'b1;
      pick   = rd_data_b;
    end
  end

  assign blocked = emit && hold_vld_r && !out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slm_pkg::MS_IDLE: begin
        if (ctrl.start) state_nxt = slm_pkg::MS_FETCH;
      end
      slm_pkg::MS_FETCH: begin
        state_nxt = run_end ? slm_pkg::MS_FINISH : slm_pkg::MS_CMP;
      end
      slm_pkg::MS_CMP: begin
        if (!blocked) state_nxt = slm_pkg::MS_FETCH;
      end
      slm_pkg::MS_FINISH: begin
        if (out_free) state_nxt = slm_pkg::MS_IDLE;
      end
      default: state_nxt = slm_pkg::MS_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    rd_en     = 1'b0;
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    load_hold = 1'b0;
    push      = 1'b0;
    finish    = 1'b0;
    case (state_r)
      slm_pkg::MS_FETCH: begin
        rd_en = 1'b1;
      end
      slm_pkg::MS_CMP: begin
        if (!blocked) begin
          adv_a     = take_a;
          adv_b     = take_b;
          load_hold = emit;
          push      = emit && hold_vld_r;
        end
      end
      slm_pkg::MS_FINISH: begin
        finish = out_free;
      end
      default: ;
    endcase
  end

  assign rd_addr_a   = ia_r[AW-1:0];
  assign rd_addr_b   = ib_r[AW-1:0];
  assign stat.busy   = state_r != slm_pkg::MS_IDLE;
  assign stat.done   = finish;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= slm_pkg::MS_IDLE;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        hold_vld_r <= 1'b0;
      end else if (load_hold) begin
        hold_vld_r <= 1'b1;
      end
      if (finish || push) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Pointers, mode latch and payload
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      ia_r    <= '0;
      ib_r    <= '0;
      inter_r <= ctrl.inter == slm_pkg::MODE_INTER;
    end else begin
      if (adv_a) ia_r <= ia_r + CW'(1);
      if (adv_b) ib_r <= ib_r + CW'(1);
    end
    if (load_hold) begin
      hold_r.out_value  <= pick;
      hold_r.no_result  <= 1'b0;
      hold_r.overflowed <= ctrl.drop;
      hold_r.run_last   <= 1'b0;
    end
    if (finish) begin
      if (hold_vld_r) begin
        out_r.out_value  <= hold_r.out_value;
        out_r.no_result  <= hold_r.no_result;
        out_r.overflowed <= hold_r.overflowed;
        out_r.run_last   <= 1'b1;
      end else begin
        out_r.out_value  <= '0;
        out_r.no_result  <= 1'b1;
        out_r.overflowed <= ctrl.drop;
        out_r.run_last   <= 1'b1;
      end
    end else if (push) begin
      out_r <= hold_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/sorted_list_merge_set_op.sv @@
// Top level of the sorted list union / intersection block: list loading,
// run bookkeeping and mode register. Uses slm_pkg, slm_store, slm_merge.
//
//  channel | ports                               | payload
//  --------+-------------------------------------+----------------------
//  input   | in_valid, in_stall, in_data         | slm_pkg::in_t
//  result  | out_valid, out_stall, out_data      | slm_pkg::out_t
//  config  | cfg_wr_en, cfg_wr_data              | set_mode (1 bit)
//
// A load transaction is accepted while in_stall is low. Once both lists are
// closed the merge runs through one comparator, each step a head read and
// then a compare of the two heads; in_stall is high throughout the run.
// Result stalls hold the compare step while the hold stage is full, and the
// finish step until the result register is free.
// Synchronous reset clears counts, flags and mode; the element stores are
// not cleared and hold nothing valid until loaded.
module sorted_list_merge_set_op #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  slm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output slm_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic          closed_a_r, closed_a_nxt, closed_b_r, closed_b_nxt;
  logic          drop_r, drop_nxt;
  logic          mode_r;

  logic          in_acc, to_b, sel_closed, sel_full, ld_act, closes, wr_en;
  logic [CW-1:0] sel_cnt;

  slm_pkg::slm_ctrl_t ctrl;
  slm_pkg::slm_stat_t stat;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr_a, rd_addr_b;
  logic signed [31:0]    rd_data_a, rd_data_b;

  // Decode the incoming transaction against its list
  assign in_stall   = stat.busy;
  assign in_acc     = in_valid && !in_stall;
  assign to_b       = in_data.which_list;
  assign sel_closed = to_b ? closed_b_r : closed_a_r;
  assign sel_cnt    = to_b ? cnt_b_r : cnt_a_r;
  assign sel_full   = sel_cnt == CW'(DEPTH);
  assign ld_act     = in_acc && !sel_closed;
  assign closes     = in_data.list_empty || in_data.list_closed;
  assign wr_en      = ld_act && !in_data.list_empty && !sel_full;

  // Start the merge when the second list closes
  assign ctrl.start = ld_act && closes && (to_b ? closed_a_r : closed_b_r);
  assign ctrl.inter = mode_r;
  assign ctrl.drop  = drop_r;

  // Run bookkeeping: advance counts, close lists, clear after the merge
  always_comb begin
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    closed_a_nxt = closed_a_r;
    closed_b_nxt = closed_b_r;
    drop_nxt     = drop_r;
    if (stat.done) begin
      cnt_a_nxt    = '0;
      cnt_b_nxt    = '0;
      closed_a_nxt = 1'b0;
      closed_b_nxt = 1'b0;
      drop_nxt     = 1'b0;
    end else if (ld_act) begin
      if (wr_en && !to_b) cnt_a_nxt = cnt_a_r + CW'(1);
      if (wr_en && to_b)  cnt_b_nxt = cnt_b_r + CW'(1);
      if (!in_data.list_empty && sel_full) drop_nxt = 1'b1;
      if (closes && !to_b) closed_a_nxt = 1'b1;
      if (closes && to_b)  closed_b_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      closed_a_r <= 1'b0;
      closed_b_r <= 1'b0;
      drop_r     <= 1'b0;
      mode_r     <= slm_pkg::MODE_UNION;
    end else begin
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      closed_a_r <= closed_a_nxt;
      closed_b_r <= closed_b_nxt;
      drop_r     <= drop_nxt;
      if (cfg_wr_en) mode_r <= cfg_wr_data;
    end
  end

  slm_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_sel    (to_b),
    .wr_addr   (sel_cnt[AW-1:0]),
    .wr_data   (in_data.element),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  slm_merge #(
    .DEPTH(DEPTH)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cnt_a     (cnt_a_r),
    .cnt_b     (cnt_b_r),
    .stat      (stat),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Counts never pass the list depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(DEPTH) && cnt_b_r <= CW'(DEPTH))
    else $error("list count beyond depth");

  // A started merge holds off further loads
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> in_stall)
    else $error("input not stalled after merge start");

  // Finishing a run presents its final result and clears the run state
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> out_valid && out_data.run_last && cnt_a_r == '0 && cnt_b_r == '0
                  && !closed_a_r && !closed_b_r)
    else $error("run end not marked or state not cleared");

  // An empty answer is always marked as the last result of its run
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_result |-> out_data.run_last)
    else $error("empty answer not marked final");

endmodule

@@ tb/tb_sorted_list_merge_set_op.sv @@
// Testbench for sorted_list_merge_set_op: loads pairs of lists, predicts the
// union / intersection answer and checks every result transaction in order.
// Depends on slm_pkg and the sorted_list_merge_set_op RTL only.
`timescale 1ns / 1ps

module tb_sorted_list_merge_set_op;

  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_ITEMS  = 380;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 4 * LIST_DEPTH + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 500000;

  // Predicts the answer of each run and holds the results still to arrive
  class merge_scoreboard;
    int                 depth;
    logic signed [31:0] list_a[$];
    logic signed [31:0] list_b[$];
    bit                 closed_a;
    bit                 closed_b;
    bit                 drop_seen;
    logic               mode;
    slm_pkg::out_t      expected_merge_q[$];
    int                 errors;
    int                 checked;
    int                 runs;
    int                 overflow_runs;

    function new(int d);
      depth = d;
      mode = slm_pkg::MODE_UNION;
      clear_lists();
    endfunction

    function void clear_lists();
      list_a.delete();
      list_b.delete();
      closed_a = 1'b0;
      closed_b = 1'b0;
      drop_seen = 1'b0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int pending();
      return expected_merge_q.size();
    endfunction

    function slm_pkg::out_t result_of(logic signed [31:0] v);
      slm_pkg::out_t r;
      r.out_value  = v;
      r.no_result  = 1'b0;
      r.overflowed = drop_seen;
      r.run_last   = 1'b0;
      return r;
    endfunction

    // Two-pointer merge over the loaded lists, then clear for the next run
    function void merge_lists();
      int            i;
      int            j;
      bit            inter;
      slm_pkg::out_t r;
      slm_pkg::out_t res[$];
      i = 0;
      j = 0;
      inter = (mode == slm_pkg::MODE_INTER);
      while (i < list_a.size() && j < list_b.size()) begin
        if (list_a[i] < list_b[j]) begin
          if (!inter) res.push_back(result_of(list_a[i]));
          i++;
        end else if (list_b[j] < list_a[i]) begin
          if (!inter) res.push_back(result_of(list_b[j]));
          j++;
        end else begin
          res.push_back(result_of(list_a[i]));
          i++;
          j++;
        end
      end
      if (!inter) begin
        while (i < list_a.size()) begin
          res.push_back(result_of(list_a[i]));
          i++;
        end
        while (j < list_b.size()) begin
          res.push_back(result_of(list_b[j]));
          j++;
        end
      end
      // empty answer still yields a single marker result
      if (res.size() == 0) begin
        r = result_of('0);
        r.no_result = 1'b1;
        res.push_back(r);
      end
      r = res[res.size() - 1];
      r.run_last = 1'b1;
      res[res.size() - 1] = r;
      foreach (res[k]) expected_merge_q.push_back(res[k]);
      runs++;
      if (drop_seen) overflow_runs++;
      clear_lists();
    endfunction

    // Note one accepted load transaction
    function void note_load(slm_pkg::in_t it);
      bit to_b;
      to_b = it.which_list;
      // drop anything aimed at a list that is already closed
      if (to_b ? closed_b : closed_a) return;
      if (it.list_empty) begin
        if (to_b) closed_b = 1'b1;
        else closed_a = 1'b1;
      end else begin
        if (to_b) begin
          if (list_b.size() < depth) list_b.push_back(it.element);
          else drop_seen = 1'b1;
          if (it.list_closed) closed_b = 1'b1;
        end else begin
          if (list_a.size() < depth) list_a.push_back(it.element);
          else drop_seen = 1'b1;
          if (it.list_closed) closed_a = 1'b1;
        end
      end
      if (closed_a && closed_b) merge_lists();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    // Check one accepted result transaction against the oldest expectation
    function void check_result(slm_pkg::out_t got);
      slm_pkg::out_t want;
      if (expected_merge_q.size() == 0) begin
        $error("unexpected result: out_value %0d no_result %0b run_last %0b",
               got.out_value, got.no_result, got.run_last);
        errors++;
        return;
      end
      want = expected_merge_q.pop_front();
      checked++;
      compare_field("out_value", want.out_value, got.out_value);
      compare_field("no_result", 32'(want.no_result), 32'(got.no_result));
      compare_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
      compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
    endfunction

    function void finish_check();
      if (expected_merge_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_merge_q.size());
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  slm_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  slm_pkg::out_t out_data;
  logic          cfg_wr_en;
  logic          cfg_wr_data;

  merge_scoreboard sb;
  bit              hold_req = 1'b0;
  int              loaded = 0;
  int              ignored = 0;
  int              mode_writes = 0;
  int              quiet_left = 0;
  int              cycle_count = 0;

  always #5 clk = ~clk;

  sorted_list_merge_set_op #(.DEPTH(LIST_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Gap before the next load: mostly none or short, a few long, quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  // List length: mostly short, now and then full or past full
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, 4);
    if (r < 94) return $urandom_range(5, LIST_DEPTH);
    return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
  endfunction

  function automatic slm_pkg::in_t mk_item(bit w, logic [31:0] v, bit c, bit e);
    slm_pkg::in_t it;
    it.which_list  = w;
    it.element     = v;
    it.list_closed = c;
    it.list_empty  = e;
    return it;
  endfunction

  // Offer one load transaction and hold it until accepted
  task automatic send_item(slm_pkg::in_t it, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_load(it);
  endtask

  // Drop valid and wait until every expected result is in and the block is quiet
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    settle_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_mode(m);
    mode_writes++;
  endtask

  // One full run: two lists with shared values, interleaved, with stray loads
  // into a list that has already closed while the other is still open
  task automatic send_run(int len_a, int len_b);
    logic signed [31:0] vals[2][$];
    slm_pkg::in_t       side_q[2][$];
    slm_pkg::in_t       it;
    logic signed [31:0] v;
    bit                 unsorted;
    int                 style;
    int                 pick;
    int                 s;
    unsorted = ($urandom_range(0, 9) == 0);
    v = $urandom;
    if ($urandom_range(0, 7) == 0) v = 32'sh8000_0000 + $urandom_range(0, 8);
    else if ($urandom_range(0, 7) == 0) v = 32'sh7fff_fff0;
    while (vals[0].size() < len_a || vals[1].size() < len_b) begin
      if (unsorted) v = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
      else if ($urandom_range(0, 9) == 0) v = v + $urandom_range(0, 32'h00ff_ffff);
      else v = v + $urandom_range(0, 3);
      pick = $urandom_range(0, 2);
      if (pick != 1 && vals[0].size() < len_a) vals[0].push_back(v);
      if (pick != 0 && vals[1].size() < len_b) vals[1].push_back(v);
    end
    // close each list by a last mark, a separate empty mark, or empty plus last
    for (s = 0; s < 2; s++) begin
      style = $urandom_range(0, 3);
      for (int k = 0; k < vals[s].size(); k++)
        side_q[s].push_back(mk_item(s[0], vals[s][k],
                                    (k == vals[s].size() - 1) && (style < 2), 1'b0));
      if (vals[s].size() == 0 || style >= 2)
        side_q[s].push_back(mk_item(s[0], $urandom,
                                    (style == 3) || ($urandom_range(0, 1) == 1), 1'b1));
    end
    while (side_q[0].size() + side_q[1].size() > 0) begin
      s = $urandom_range(0, 1);
      if (side_q[s].size() == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(mk_item(s[0], $urandom, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))),
                    pick_gap());
          ignored++;
        end
        s = 1 - s;
      end
      it = side_q[s].pop_front();
      send_item(it, pick_gap());
      loaded++;
    end
  endtask

  // Result side: random stall pattern, plus one long hold-off on request
  initial begin : result_sink
    int   span_left;
    int   hold_left;
    int   pick;
    logic stall_next;
    span_left = 0;
    hold_left = 0;
    stall_next = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
        span_left = 0;
      end else if (span_left > 0) begin
        span_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          stall_next = 1'b0;
          span_left = $urandom_range(0, 6);
        end else if (pick < 60) begin
          stall_next = 1'b0;
          span_left = $urandom_range(20, 80);
        end else if (pick < 92) begin
          stall_next = 1'b1;
          span_left = $urandom_range(0, 2);
        end else begin
          stall_next = 1'b1;
          span_left = $urandom_range(10, 40);
        end
      end
      out_stall <= stall_next;
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && sb != null && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Run limit
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    int random_start;
    int run_no;
    int len_a;
    int len_b;
    sb = new(LIST_DEPTH);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Union: extremes of the value range, empty list against one element,
    // both lists empty giving the empty answer
    write_mode(slm_pkg::MODE_UNION);
    send_item(mk_item(1'b0, 32'sh8000_0000, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sh0000_0000, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sh0000_0000, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sh7fff_ffff, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'shdead_beef, 1'b0, 1'b1), pick_gap());
    send_item(mk_item(1'b1, 32'sh0000_0007, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'shffff_ffff, 1'b1, 1'b1), pick_gap());
    send_item(mk_item(1'b1, 32'sh5555_5555, 1'b0, 1'b1), pick_gap());

    // Intersection: overlap, disjoint lists, a load into a closed list,
    // empty mark on a started list, and a list out of order
    write_mode(slm_pkg::MODE_INTER);
    send_item(mk_item(1'b0, 32'sd1, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sd2, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd2, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sd3, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd3, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sd4, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd1, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sd2, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd5, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd99, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sd5, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd9, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd0, 1'b0, 1'b1), pick_gap());
    send_item(mk_item(1'b1, 32'sd9, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd3, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sd1, 1'b0, 1'b0), pick_gap());
    send_item(mk_item(1'b0, 32'sd1, 1'b1, 1'b0), pick_gap());
    send_item(mk_item(1'b1, 32'sd3, 1'b1, 1'b0), pick_gap());

    // Random runs in phases of alternating mode, the last phase in a random mode;
    // one phase starts under a long result hold-off so the block backs up into its input
    random_start = loaded;
    run_no = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) write_mode(1'($urandom_range(0, 1)));
      else if (phase % 2 == 0) write_mode(slm_pkg::MODE_UNION);
      else write_mode(slm_pkg::MODE_INTER);
      if (phase == 2) hold_req = 1'b1;
      phase_end = random_start + (phase + 1) * RANDOM_ITEMS / PHASES;
      while (loaded < phase_end) begin
        len_a = pick_len();
        len_b = pick_len();
        if (run_no % 13 == 6) len_a = LIST_DEPTH + $urandom_range(1, 3);
        if (run_no % 13 == 11) len_b = LIST_DEPTH + $urandom_range(1, 3);
        send_run(len_a, len_b);
        run_no++;
      end
    end

    settle_idle();
    sb.finish_check();
    $display("Covered %0d list pairs (%0d with dropped elements) from %0d loads, %0d stray.",
             sb.runs, sb.overflow_runs, loaded, ignored);
    $display("Checked %0d results over %0d mode register writes in %0d cycles.",
             sb.checked, mode_writes, cycle_count);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/slm_pkg.sv
hw/rtl/slm_store.sv
hw/rtl/slm_merge.sv
hw/rtl/sorted_list_merge_set_op.sv
tb/tb_sorted_list_merge_set_op.sv
